[rtl/prime_sieve_lister_assert.svh]
// Assertion macros for the prime sieve lister.
`ifndef PRIME_SIEVE_LISTER_ASSERT_SVH
`define PRIME_SIEVE_LISTER_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define PSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define PSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/psl_pkg.sv]
// Shared constants for the prime sieve lister.
`default_nettype none

package psl_pkg;

  localparam int unsigned LIMIT_W       = 9;
  localparam int unsigned MAX_LIMIT_DEF = 256;
  localparam int unsigned FIRST_PRIME   = 2;

endpackage

`default_nettype wire

[rtl/psl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module psl_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/psl_alu.sv]
// Shared adder with bound compare used by every sieve loop.
`default_nettype none

module psl_alu #(
  parameter int unsigned VW = 10
) (
  input  wire logic [VW-1:0] a_i,
  input  wire logic [VW-1:0] b_i,
  input  wire logic [VW-1:0] bound_i,
  output logic      [VW-1:0] sum_o,
  output logic               le_o
);

  always_comb begin
    sum_o = a_i + b_i;
    le_o  = (sum_o <= bound_i);
  end

endmodule

`default_nettype wire

[rtl/prime_sieve_lister.sv]
// Prime sieve lister: sequencer, composite store and result register.
//
// Input channel: in_valid_i/in_stall_o with limit_i. One request carries an
// upper limit; limits above MAX_LIMIT saturate to MAX_LIMIT.
// Output channel: out_valid_o/out_stall_i with prime_o, none_found_o, last_o.
// The primes up to the limit come out in ascending order, last_o marks the
// final one. A limit below two gives one result with none_found_o set.
// in_stall_o is high from the accept until the final result of a request
// sits in the output register; one request is worked on at a time.
// Steps for limit L (saturated): initialise the store up to L, then for each
// sieve candidate up to sqrt(L) read its flag and mark its multiples from its
// square, then read and check each scanned number in turn. The store has one
// write and one read port, and the one adder is shared by all these steps.
// A stalled receiver holds the scan until the output register frees up.
// Reset clears the sequencer and the output valid; the store needs no
// clearing since each request rewrites it before reading it.
`default_nettype none

module prime_sieve_lister #(
  parameter int unsigned MAX_LIMIT = psl_pkg::MAX_LIMIT_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [psl_pkg::LIMIT_W-1:0]  limit_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [psl_pkg::LIMIT_W-1:0]  prime_o,
  output logic                              none_found_o,
  output logic                              last_o
);

  import psl_pkg::*;

  `include "prime_sieve_lister_assert.svh"

  localparam int unsigned DEPTH = MAX_LIMIT + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned VW    = $clog2(2 * MAX_LIMIT + 2);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_NONE  = 4'd1;
  localparam logic [3:0] ST_CLR   = 4'd2;
  localparam logic [3:0] ST_ORD   = 4'd3;
  localparam logic [3:0] ST_OCHK  = 4'd4;
  localparam logic [3:0] ST_MARK  = 4'd5;
  localparam logic [3:0] ST_ONXT  = 4'd6;
  localparam logic [3:0] ST_SRD   = 4'd7;
  localparam logic [3:0] ST_SCHK  = 4'd8;
  localparam logic [3:0] ST_FLUSH = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [VW-1:0]      lim_q, lim_d;
  logic [VW-1:0]      i_q, i_d;
  logic [VW-1:0]      j_q, j_d;
  logic [VW-1:0]      sq_q, sq_d;
  logic [VW-1:0]      pend_q, pend_d;
  logic               pend_valid_q, pend_valid_d;
  logic               out_valid_q, out_valid_d;
  logic [LIMIT_W-1:0] out_prime_q, out_prime_d;
  logic               out_none_q, out_none_d;
  logic               out_last_q, out_last_d;

  logic [VW-1:0] alu_a, alu_b, alu_sum;
  logic          alu_le;
  logic          ram_we, ram_re, ram_wdata, ram_rdata;
  logic          can_emit, accept;

  psl_alu #(.VW(VW)) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .bound_i (lim_q),
    .sum_o   (alu_sum),
    .le_o    (alu_le)
  );

  psl_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_flags (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (j_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign can_emit = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    lim_d        = lim_q;
    i_d          = i_q;
    j_d          = j_q;
    sq_d         = sq_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_prime_d  = out_prime_q;
    out_none_d   = out_none_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && out_stall_i;
    alu_a        = j_q;
    alu_b        = VW'(1);
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_wdata    = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pend_valid_d = 1'b0;
          j_d          = '0;
          if (limit_i > LIMIT_W'(MAX_LIMIT)) begin
            lim_d = VW'(MAX_LIMIT);
          end else begin
            lim_d = VW'(limit_i);
          end
          if (limit_i < LIMIT_W'(FIRST_PRIME)) begin
            state_d = ST_NONE;
          end else begin
            state_d = ST_CLR;
          end
        end
      end
      ST_NONE: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_prime_d = '0;
          out_none_d  = 1'b1;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_CLR: begin
        // zero and one are not prime, everything else starts unmarked
        ram_we    = 1'b1;
        ram_wdata = (j_q < VW'(FIRST_PRIME));
        alu_a     = j_q;
        alu_b     = VW'(1);
        if (alu_le) begin
          j_d = alu_sum;
        end else begin
          i_d     = VW'(FIRST_PRIME);
          sq_d    = VW'(FIRST_PRIME * FIRST_PRIME);
          state_d = ST_ORD;
        end
      end
      ST_ORD: begin
        if (sq_q > lim_q) begin
          i_d     = VW'(FIRST_PRIME);
          state_d = ST_SRD;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_OCHK;
        end
      end
      ST_OCHK: begin
        if (!ram_rdata) begin
          j_d     = sq_q;
          state_d = ST_MARK;
        end else begin
          state_d = ST_ONXT;
        end
      end
      ST_MARK: begin
        ram_we = 1'b1;
        alu_a  = j_q;
        alu_b  = i_q;
        if (alu_le) begin
          j_d = alu_sum;
        end else begin
          state_d = ST_ONXT;
        end
      end
      ST_ONXT: begin
        // (i+1)^2 = i^2 + 2i + 1
        alu_a   = sq_q;
        alu_b   = {i_q[VW-2:0], 1'b1};
        sq_d    = alu_sum;
        i_d     = i_q + VW'(1);
        state_d = ST_ORD;
      end
      ST_SRD: begin
        ram_re  = 1'b1;
        state_d = ST_SCHK;
      end
      ST_SCHK: begin
        alu_a = i_q;
        alu_b = VW'(1);
        // a prime is held back one step so the largest can carry last
        if (!ram_rdata && pend_valid_q && !can_emit) begin
          state_d = ST_SCHK;
        end else begin
          if (!ram_rdata) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_prime_d = LIMIT_W'(pend_q);
              out_none_d  = 1'b0;
              out_last_d  = 1'b0;
            end
            pend_d       = i_q;
            pend_valid_d = 1'b1;
          end
          if (alu_le) begin
            i_d     = alu_sum;
            state_d = ST_SRD;
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          out_valid_d  = 1'b1;
          out_prime_d  = LIMIT_W'(pend_q);
          out_none_d   = 1'b0;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q       <= lim_d;
    i_q         <= i_d;
    j_q         <= j_d;
    sq_q        <= sq_d;
    pend_q      <= pend_d;
    out_prime_q <= out_prime_d;
    out_none_q  <= out_none_d;
    out_last_q  <= out_last_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign prime_o      = out_prime_q;
  assign none_found_o = out_none_q;
  assign last_o       = out_last_q;

  `PSL_ASSERT_NXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o,
                  "request accepted but block not busy next cycle")
  `PSL_ASSERT_IMP(a_mark_in_range, state_q == ST_MARK, j_q <= lim_q,
                  "marking beyond the limit")
  `PSL_ASSERT_IMP(a_sq_tracks_i, state_q == ST_ORD, sq_q == i_q * i_q,
                  "square register out of step with candidate")
  `PSL_ASSERT_IMP(a_flush_has_prime, state_q == ST_FLUSH, pend_valid_q,
                  "final flush without a held prime")
  `PSL_ASSERT_IMP(a_none_is_last, out_valid_o && none_found_o,
                  last_o && (prime_o == '0),
                  "none found result must be last and zero")

endmodule

`default_nettype wire
